>>> rtl/tpm_pkg.sv
// Shared types and constants for the three-phase top selection block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tpm_pkg;

    // Sizes of the phase store and of the stream fields
    localparam int MAX_PHASES  = 16;
    localparam int PH_W        = 4;
    localparam int COEF_W      = 32;
    localparam int SUM_W       = 36;
    localparam int CFG_W       = 5;
    localparam int CNT_W       = 2;
    localparam int MASK_W      = 16;
    localparam int NUM_SLOTS   = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);
    localparam logic [CFG_W-1:0] ACTIVE_LIMIT = CFG_W'(MAX_PHASES);
    localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(NUM_SLOTS);

    // Controller states
    typedef enum logic [1:0] {
        S_ACC,
        S_SCAN,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic acc_en;
        logic scan_start;
        logic scan_en;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/top_three_phase_mask.sv
// Top level of the three-phase top selection block.
// Depends on tpm_pkg, tpm_ctrl and tpm_dp.
`timescale 1ns / 1ps

// Sums unsigned Q16.16 coefficients per phase (saturating at 36 bits) and, on the
// transfer marked tlast, picks up to three phases with the largest strictly positive
// sums among phases below active_phases (lowest index wins ties), returns a keep mask
// and the choices, then clears all sums. A coefficient is taken every cycle while the
// block accumulates; a sample end stalls the input for a scan of the phase store
// through one compare unit, one phase at a time, then for the load of the output
// register that clears the sums, which waits while the previous result is still held.
module top_three_phase_mask import tpm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,      // active_phases
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,    // coefficient, phase_index, zero pad
    input  logic                   s_axis_tlast,    // last_of_sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata     // keep_mask, first_choice,
                                                    // second_choice, third_choice,
                                                    // chosen_count, zero pad
);

    logic [CFG_W-1:0] r_active_phases;
    logic [CFG_W-1:0] eff_phases;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_phases <= ACTIVE_RESET;
        end else if (i_cfg_valid) begin
            r_active_phases <= i_cfg_data;
        end
    end

    assign eff_phases = (r_active_phases > ACTIVE_LIMIT) ? ACTIVE_LIMIT : r_active_phases;

    tpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tpm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_coef       (s_axis_tdata[COEF_W-1:0]),
        .i_phase      (s_axis_tdata[COEF_W+PH_W-1:COEF_W]),
        .i_eff_phases (eff_phases),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata)
    );

    // No input transfer while the scan runs
    a_no_input_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_en |-> !s_axis_tready)
        else $error("input accepted during phase scan");

    // Mask bits agree with the reported count
    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(m_axis_tdata[MASK_W-1:0]) ==
                           int'(m_axis_tdata[MASK_W+3*PH_W+CNT_W-1:MASK_W+3*PH_W])))
        else $error("keep mask does not match chosen count");

    // A result only appears after a load command
    a_load_before_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.load_out))
        else $error("result valid without load");

    // Sums are cleared on load, so no accumulate in the same cycle
    a_load_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !cmd.acc_en)
        else $error("accumulate collides with sum clear");

endmodule

>>> rtl/tpm_ctrl.sv
// Controller state machine: accumulate, scan phases, emit result.
// Depends on tpm_pkg.
`timescale 1ns / 1ps

module tpm_ctrl import tpm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc_en = 1'b1;
                    if (i_in_last) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // load result and clear sums once the output register is free
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

endmodule

>>> rtl/tpm_dp.sv
// Datapath: per-phase saturating sums, top-three scan unit, output register.
// Depends on tpm_pkg.
`timescale 1ns / 1ps

module tpm_dp import tpm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [COEF_W-1:0]      i_coef,
    input  logic [PH_W-1:0]        i_phase,
    input  logic [CFG_W-1:0]       i_eff_phases,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    logic [SUM_W-1:0]       r_sum [MAX_PHASES];
    logic [PH_W-1:0]        r_scan_idx;
    logic [SUM_W-1:0]       r_top_val [NUM_SLOTS];
    logic [PH_W-1:0]        r_top_idx [NUM_SLOTS];
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [PH_W-1:0]  rd_addr;
    logic [SUM_W-1:0] rd_val;
    logic [SUM_W:0]   acc_sum;
    logic [SUM_W-1:0] acc_sat;
    logic             eligible;
    logic             gt0, gt1, gt2;
    logic [MASK_W-1:0] keep_mask;

    // One read port: scan index while scanning, else the incoming phase
    assign rd_addr = i_cmd.scan_en ? r_scan_idx : i_phase;
    assign rd_val  = r_sum[rd_addr];

    // Saturating accumulate
    assign acc_sum = {1'b0, rd_val} + (SUM_W+1)'(i_coef);
    assign acc_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            for (int k = 0; k < MAX_PHASES; k++) begin
                r_sum[k] <= '0;
            end
        end else if (i_cmd.acc_en) begin
            r_sum[i_phase] <= acc_sat;
        end
    end

    // Scan: sorted insert into three slots, strict compare keeps lower index on ties
    assign eligible = ({1'b0, r_scan_idx} < i_eff_phases);
    assign gt0      = eligible && (rd_val > r_top_val[0]);
    assign gt1      = eligible && (rd_val > r_top_val[1]);
    assign gt2      = eligible && (rd_val > r_top_val[2]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
            r_cnt      <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_top_val[i] <= '0;
                r_top_idx[i] <= '0;
            end
        end else if (i_cmd.scan_en) begin
            r_scan_idx <= r_scan_idx + 1'b1;
            if (gt2 && (r_cnt != CNT_FULL)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (gt0) begin
                r_top_val[0] <= rd_val;       r_top_idx[0] <= r_scan_idx;
                r_top_val[1] <= r_top_val[0]; r_top_idx[1] <= r_top_idx[0];
                r_top_val[2] <= r_top_val[1]; r_top_idx[2] <= r_top_idx[1];
            end else if (gt1) begin
                r_top_val[1] <= rd_val;       r_top_idx[1] <= r_scan_idx;
                r_top_val[2] <= r_top_val[1]; r_top_idx[2] <= r_top_idx[1];
            end else if (gt2) begin
                r_top_val[2] <= rd_val;       r_top_idx[2] <= r_scan_idx;
            end
        end
    end

    assign o_sts.scan_last = (r_scan_idx == PH_W'(MAX_PHASES - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Keep mask from the valid slots
    always_comb begin
        keep_mask = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (CNT_W'(i) < r_cnt) begin
                keep_mask[r_top_idx[i]] = 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {2'b00, r_cnt, r_top_idx[2], r_top_idx[1], r_top_idx[0],
                           keep_mask};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
